### hw/rtl/lzss_pkg.sv
// Shared constants and controller/datapath command and status types for the LZSS decoder.
package lzss_pkg;

   localparam int WINDOW_SIZE_DEF     = 4096;
   localparam int MAX_MATCH_DEF       = 18;
   localparam int MATCH_THRESHOLD_DEF = 2;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 12;

   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

   typedef struct packed {
      logic clear_stream;
      logic hold_low;
      logic take_lit;
      logic start_copy;
      logic reduce;
      logic read;
      logic emit;
      logic use_lit;
      logic last;
   } dp_cmd_type;

   typedef struct packed {
      logic src_high;
      logic out_free;
   } dp_status_type;

endpackage

### hw/rtl/lzss_if.sv
// Valid/ready channel interfaces for compressed input and decompressed output transactions.
interface lzss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_of_stream;

   modport source (output valid, output in_byte, output start_of_stream, input ready);
   modport sink   (input valid, input in_byte, input start_of_stream, output ready);
endinterface

interface lzss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

### hw/rtl/lzss_datapath.sv
// Datapath: window memory, write position, fill count, copy source and output register.
module lzss_datapath #(
   parameter int WINDOW_SIZE = lzss_pkg::WINDOW_SIZE_DEF,
   parameter int MAX_MATCH   = lzss_pkg::MAX_MATCH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            in_byte,
   input  lzss_pkg::dp_cmd_type  cmd,
   output lzss_pkg::dp_status_type status,
   lzss_rsp_if.source            rsp
);
   import lzss_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int FW = $clog2(WINDOW_SIZE + 1);
   localparam logic [AW-1:0] START_POS = AW'(WINDOW_SIZE - MAX_MATCH);
   localparam logic [AW-1:0] LAST_POS  = AW'(WINDOW_SIZE - 1);

   logic [BYTE_W-1:0] mem [WINDOW_SIZE];

   logic [AW-1:0]     wp_ff, wp_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [POS_W-1:0]  src_ff, src_in;
   logic [BYTE_W-1:0] held_ff;
   logic [BYTE_W-1:0] lit_ff;
   logic [BYTE_W-1:0] rd_ff;
   logic              hit_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;

   logic [AW-1:0]     src_addr;
   logic [AW-1:0]     src_offset;
   logic              src_written;
   logic [BYTE_W-1:0] emit_byte;

   assign src_addr    = src_ff[AW-1:0];
   assign src_offset  = (src_addr >= START_POS) ? (src_addr - START_POS)
                                                : (src_addr + AW'(MAX_MATCH));
   assign src_written = FW'(src_offset) < fill_ff;
   assign emit_byte   = cmd.use_lit ? lit_ff : (hit_ff ? rd_ff : SPACE_CHAR);

   assign status.src_high = {1'b0, src_ff} >= (POS_W + 1)'(WINDOW_SIZE);
   assign status.out_free = !out_valid_ff || rsp.ready;

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.last_of_run = out_last_ff;

   always_comb begin
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      src_in       = src_ff;
      out_valid_in = out_valid_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.clear_stream) begin
         wp_in   = START_POS;
         fill_in = '0;
      end
      if (cmd.start_copy) begin
         src_in = {in_byte[7:4], held_ff};
      end
      if (cmd.reduce) begin
         src_in = src_ff - POS_W'(WINDOW_SIZE);
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         wp_in        = (wp_ff == LAST_POS) ? '0 : wp_ff + 1'b1;
         if (fill_ff != FW'(WINDOW_SIZE)) begin
            fill_in = fill_ff + 1'b1;
         end
         if (!cmd.use_lit) begin
            src_in = POS_W'((src_addr == LAST_POS) ? '0 : src_addr + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= START_POS;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      if (cmd.hold_low) begin
         held_ff <= in_byte;
      end
      if (cmd.take_lit) begin
         lit_ff <= in_byte;
      end
      if (cmd.emit) begin
         out_byte_ff <= emit_byte;
         out_last_ff <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         mem[wp_ff] <= emit_byte;
      end
      if (cmd.read) begin
         rd_ff  <= mem[src_addr];
         hit_ff <= src_written;
      end
   end

endmodule

### hw/rtl/lzss_controller.sv
// Controller: flag and token parsing, copy length count and sequencing of the datapath.
module lzss_controller #(
   parameter int MAX_MATCH       = lzss_pkg::MAX_MATCH_DEF,
   parameter int MATCH_THRESHOLD = lzss_pkg::MATCH_THRESHOLD_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   lzss_req_if.sink                req,
   output lzss_pkg::dp_cmd_type    cmd,
   input  lzss_pkg::dp_status_type status
);
   import lzss_pkg::*;

   localparam int CW = $clog2(MAX_MATCH + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] flags_ff, flags_in;
   logic [3:0]        remaining_ff, remaining_in;
   logic              phase_ff, phase_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              lit_mode_ff, lit_mode_in;

   logic [3:0]        eff_remaining;
   logic              eff_phase;
   int                len_full;
   logic [CW-1:0]     copy_len;

   assign eff_remaining = req.start_of_stream ? 4'd0 : remaining_ff;
   assign eff_phase     = req.start_of_stream ? 1'b0 : phase_ff;
   assign len_full      = int'(req.in_byte[3:0]) + MATCH_THRESHOLD + 1;
   assign copy_len      = (len_full > MAX_MATCH) ? CW'(MAX_MATCH) : CW'(len_full);

   always_comb begin
      state_in     = state_ff;
      flags_in     = flags_ff;
      remaining_in = remaining_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      lit_mode_in  = lit_mode_ff;
      cmd          = '0;
      cmd.use_lit  = lit_mode_ff;
      cmd.last     = (cnt_ff == CW'(1));
      req.ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd.clear_stream = req.start_of_stream;
               if (req.start_of_stream) begin
                  remaining_in = 4'd0;
                  phase_in     = 1'b0;
               end
               if (eff_phase) begin
                  cmd.start_copy = 1'b1;
                  cnt_in         = copy_len;
                  lit_mode_in    = 1'b0;
                  phase_in       = 1'b0;
                  flags_in       = flags_ff >> 1;
                  if (remaining_ff != 4'd0) begin
                     remaining_in = remaining_ff - 4'd1;
                  end
                  state_in = ST_FETCH;
               end else if (eff_remaining == 4'd0) begin
                  flags_in     = req.in_byte;
                  remaining_in = 4'd8;
               end else if (flags_ff[0]) begin
                  cmd.take_lit = 1'b1;
                  cnt_in       = CW'(1);
                  lit_mode_in  = 1'b1;
                  flags_in     = flags_ff >> 1;
                  remaining_in = eff_remaining - 4'd1;
                  state_in     = ST_EMIT;
               end else begin
                  cmd.hold_low = 1'b1;
                  phase_in     = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            if (status.src_high) begin
               cmd.reduce = 1'b1;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cnt_in   = cnt_ff - CW'(1);
               state_in = (cnt_ff == CW'(1)) ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         remaining_ff <= '0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         lit_mode_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         remaining_ff <= remaining_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         lit_mode_ff  <= lit_mode_in;
      end
   end

endmodule

### hw/rtl/lzss_stream_decoder.sv
// Top level: LZSS stream decoder with sliding window, controller and datapath.
// Flag bytes and the first byte of a copy token are taken in the idle state; a literal
// passes through the emit state before the next byte is accepted.
// A copy does a window read then a write per byte, and first takes the window size off
// a source position beyond the window as often as needed; output stalls hold each write.
// Synchronous reset; reset and start_of_stream clear via a fill count, no clearing pass.
module lzss_stream_decoder #(
   parameter int WINDOW_SIZE     = lzss_pkg::WINDOW_SIZE_DEF,
   parameter int MAX_MATCH       = lzss_pkg::MAX_MATCH_DEF,
   parameter int MATCH_THRESHOLD = lzss_pkg::MATCH_THRESHOLD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lzss_req_if.sink   req_bus,
   lzss_rsp_if.source rsp_bus
);
   import lzss_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lzss_controller #(
      .MAX_MATCH       (MAX_MATCH),
      .MATCH_THRESHOLD (MATCH_THRESHOLD)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .cmd    (cmd),
      .status (status)
   );

   lzss_datapath #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .MAX_MATCH   (MAX_MATCH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .in_byte (req_bus.in_byte),
      .cmd     (cmd),
      .status  (status),
      .rsp     (rsp_bus)
   );

endmodule

### sim/lzss_stream_decoder_checker.sv
// Checker for the LZSS stream decoder: watches both channels, predicts output bytes and compares.
`timescale 1ns / 1ps
module lzss_stream_decoder_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [lzss_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                        req_start_of_stream,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [lzss_pkg::BYTE_W-1:0] rsp_out_byte,
   input  logic                        rsp_last_of_run,
   output int                          fail_count,
   output int                          checked_count,
   output int                          outstanding
);
   import lzss_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } out_beat_type;

   out_beat_type      expected_bytes[$];
   logic [BYTE_W-1:0] history[WINDOW_SIZE_DEF];
   logic [POS_W-1:0]  wr_pos;
   logic [BYTE_W-1:0] flag_reg;
   int                flags_left;
   logic              copy_pending;
   logic [BYTE_W-1:0] pos_low;

   task automatic clear_window();
      for (int i = 0; i < WINDOW_SIZE_DEF; i++) history[i] = SPACE_CHAR;
      wr_pos       = POS_W'(WINDOW_SIZE_DEF - MAX_MATCH_DEF);
      flag_reg     = '0;
      flags_left   = 0;
      copy_pending = 1'b0;
      pos_low      = '0;
   endtask

   task automatic take_flag();
      flag_reg = flag_reg >> 1;
      if (flags_left > 0) flags_left--;
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic sos);
      logic [POS_W-1:0] src;
      int               run_len;
      out_beat_type     beat;
      if (sos) clear_window();
      if (copy_pending) begin
         src     = {b[7:4], pos_low};
         run_len = int'(b[3:0]) + MATCH_THRESHOLD_DEF + 1;
         if (run_len > MAX_MATCH_DEF) run_len = MAX_MATCH_DEF;
         for (int k = 0; k < run_len; k++) begin
            beat.data       = history[src];
            beat.last       = (k == run_len - 1);
            history[wr_pos] = beat.data;
            wr_pos++;
            src++;
            expected_bytes.push_back(beat);
         end
         copy_pending = 1'b0;
         take_flag();
      end else if (flags_left == 0) begin
         flag_reg   = b;
         flags_left = 8;
      end else if (flag_reg[0]) begin
         history[wr_pos] = b;
         wr_pos++;
         beat.data = b;
         beat.last = 1'b1;
         expected_bytes.push_back(beat);
         take_flag();
      end else begin
         pos_low      = b;
         copy_pending = 1'b1;
      end
   endtask

   task automatic check_beat();
      out_beat_type want;
      if (expected_bytes.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected output transaction out_byte=%02h last_of_run=%0b",
                  $time, rsp_out_byte, rsp_last_of_run);
      end else begin
         want = expected_bytes.pop_front();
         checked_count++;
         if (rsp_out_byte !== want.data) begin
            fail_count++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.data, rsp_out_byte);
         end
         if (rsp_last_of_run !== want.last) begin
            fail_count++;
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last, rsp_last_of_run);
         end
      end
   endtask

   initial begin
      fail_count    = 0;
      checked_count = 0;
      outstanding   = 0;
      clear_window();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_window();
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_beat();
         if (req_valid && req_ready) decode_byte(req_in_byte, req_start_of_stream);
      end
      outstanding = expected_bytes.size();
   end

endmodule

### sim/lzss_stream_decoder_tb.sv
// Testbench top for the LZSS stream decoder: clock, reset, compressed stream stimulus and verdict.
`timescale 1ns / 1ps
module lzss_stream_decoder_tb;
   import lzss_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_PER_PHASE = 90;
   localparam int DIRECTED_COUNT   = 20;
   localparam int SETTLE_CYCLES    = 60;

   // {start_of_stream, in_byte}
   localparam logic [8:0] DIRECTED_BYTES[DIRECTED_COUNT] = '{
      {1'b1, 8'hA5},                 // flags: lit, copy, lit, copy, copy, lit, copy
      {1'b0, 8'h00},
      {1'b0, 8'hFE}, {1'b0, 8'hFF},  // longest copy, wraps on read and write
      {1'b0, 8'hFF},
      {1'b0, 8'h01}, {1'b0, 8'h00},  // overlapping copy of the byte just written
      {1'b0, 8'h00}, {1'b0, 8'h0F},
      {1'b0, 8'h5A},
      {1'b0, 8'h34},                 // copy cut off by the next start
      {1'b1, 8'h00},                 // all copies
      {1'b0, 8'h12}, {1'b0, 8'h34},
      {1'b0, 8'hFF}, {1'b0, 8'hF0},  // shortest copy from the last window entry
      {1'b1, 8'hFF},                 // all literals
      {1'b0, 8'h80}, {1'b0, 8'h7F}, {1'b0, 8'h01}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count;
   int checked_count;
   int outstanding;
   int tx_idle_pct;
   int rx_idle_pct;
   int sent_count;
   int stream_count;
   int cycle_count;

   lzss_req_if req_chan();
   lzss_rsp_if rsp_chan();

   always #5 clock = ~clock;

   lzss_stream_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan)
   );

   lzss_stream_decoder_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_chan.valid),
      .req_ready           (req_chan.ready),
      .req_in_byte         (req_chan.in_byte),
      .req_start_of_stream (req_chan.start_of_stream),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_out_byte        (rsp_chan.out_byte),
      .rsp_last_of_run     (rsp_chan.last_of_run),
      .fail_count          (fail_count),
      .checked_count       (checked_count),
      .outstanding         (outstanding)
   );

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic sos);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid           <= 1'b1;
      req_chan.in_byte         <= b;
      req_chan.start_of_stream <= sos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Well-formed stream; when cut is set it stops inside its last group,
   // possibly between the two bytes of a copy.
   task automatic send_stream(input int groups, input logic cut);
      logic [7:0]       flags;
      logic [POS_W-1:0] wpos;
      logic [POS_W-1:0] src;
      logic [3:0]       len_code;
      int               cut_idx;
      logic             cut_here;
      wpos    = POS_W'(WINDOW_SIZE_DEF - MAX_MATCH_DEF);
      cut_idx = int'($urandom_range(8)) - 1;
      stream_count++;
      for (int g = 0; g < groups; g++) begin
         cut_here = cut && (g == groups - 1);
         flags    = 8'($urandom);
         send_byte(flags, g == 0);
         if (cut_here && cut_idx < 0) return;
         for (int i = 0; i < 8; i++) begin
            if (flags[i]) begin
               if (cut_here && i == cut_idx) return;
               send_byte(8'($urandom), 1'b0);
               wpos++;
            end else begin
               case ($urandom_range(3))
                  0, 1: src = wpos - POS_W'($urandom_range(1, 24));
                  2: src = POS_W'($urandom);
                  default: src = POS_W'(WINDOW_SIZE_DEF - $urandom_range(1, 20));
               endcase
               len_code = 4'($urandom);
               send_byte(src[7:0], 1'b0);
               if (cut_here && i == cut_idx) return;
               send_byte({src[11:8], len_code}, 1'b0);
               wpos += POS_W'(len_code) + POS_W'(MATCH_THRESHOLD_DEF + 1);
            end
         end
      end
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         send_byte(8'($urandom), (i == 0) ? 1'($urandom) : ($urandom_range(9) == 0));
      end
   endtask

   initial begin
      req_chan.valid           = 1'b0;
      req_chan.in_byte         = '0;
      req_chan.start_of_stream = 1'b0;
      rsp_chan.ready           = 1'b0;
      tx_idle_pct              = 0;
      rx_idle_pct              = 0;
      sent_count               = 0;
      stream_count             = 0;
      cycle_count              = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
      end
      drain_results();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 88 : 0;
         rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 22 : 0;
         while (sent_count < DIRECTED_COUNT + (ph + 1) * RANDOM_PER_PHASE) begin
            if ($urandom_range(7) == 0) send_noise();
            else send_stream($urandom_range(1, 3), $urandom_range(3) == 0);
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d compressed bytes (%0d random streams plus noise and directed cases),",
               sent_count, stream_count);
      $display("checked %0d decoded bytes, %0d failures.", checked_count, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
